@@ rtl/core/dlac_pkg.sv @@
// shared types, constants and helpers of the dipole lag autocorrelator
`default_nettype none

package dlac_pkg;

	localparam int LAGS_DEF   = 128;

	localparam int CMD_W      = 3;
	localparam int POS_W      = 24;
	localparam int CHG_W      = 16;
	localparam int SEL_W      = 7;
	localparam int CNT_W      = 32;
	localparam int ACC_W      = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int AXES       = 3;
	localparam int AX_IDX_W   = 2;

	localparam int CP_W       = CHG_W + POS_W;
	localparam int CS_W       = CP_W + 1;
	localparam int DIP_SHIFT  = 11;
	localparam int DIP_W      = CS_W - DIP_SHIFT;
	localparam int PROD_W     = 2 * DIP_W;
	localparam int DOT_W      = PROD_W + 2;
	localparam int FRAC_SHIFT = 16;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic signed [CHG_W-1:0] charge_t;
	typedef logic signed [DIP_W-1:0] dip_t;
	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic [CNT_W-1:0]        cnt_t;

	typedef struct packed {
		dip_t x;
		dip_t y;
		dip_t z;
	} vec_t;

	typedef struct packed {
		logic upd;
		logic clr;
	} step_ctrl_t;

	typedef struct packed {
		logic v;
		acc_t data;
	} rd_tok_t;

	localparam logic [CMD_W-1:0] CMD_SAMPLE   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_READ_LAG = 3'd1;
	localparam logic [CMD_W-1:0] CMD_READ_SUM = 3'd2;
	localparam logic [CMD_W-1:0] CMD_READ_SQ  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_CHARGE_OXYGEN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHARGE_HYDROGEN = 2'd1;

	localparam charge_t CO_RESET = -16'sd27774;
	localparam charge_t CH_RESET = 16'sd13887;

	localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	function automatic acc_t sat_add(acc_t a, acc_t b);
		logic signed [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1]) begin
			return s[ACC_W] ? ACC_MIN : ACC_MAX;
		end
		return s[ACC_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/dlac_ifs.sv @@
// request, response and configuration channel interfaces
`default_nettype none

interface dlac_req_if
	import dlac_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	pos_t              oxygen_x;
	pos_t              oxygen_y;
	pos_t              oxygen_z;
	pos_t              hydrogen_x;
	pos_t              hydrogen_y;
	pos_t              hydrogen_z;
	logic [SEL_W-1:0]  select_index;

	modport source (
		output valid, command, oxygen_x, oxygen_y, oxygen_z,
		       hydrogen_x, hydrogen_y, hydrogen_z, select_index,
		input  ready
	);
	modport sink (
		input  valid, command, oxygen_x, oxygen_y, oxygen_z,
		       hydrogen_x, hydrogen_y, hydrogen_z, select_index,
		output ready
	);
endinterface

interface dlac_rsp_if
	import dlac_pkg::*;
();
	logic valid;
	logic ready;
	acc_t value;
	cnt_t pair_count;

	modport source (output valid, value, pair_count, input ready);
	modport sink (input valid, value, pair_count, output ready);
endinterface

interface dlac_cfg_if
	import dlac_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	charge_t              data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/dipole_lag_autocorrelator_top.sv @@
// top level: controller, dipole former, lag cell chain and axis moments
//
// req carries one request: command, oxygen and hydrogen positions in q12.12
// and select_index. rsp returns value (q32.32) and pair_count for the three
// read commands; sample, clear and unknown commands return nothing.
// cfg writes the two charge registers (index 0 oxygen, 1 hydrogen); it is
// always ready and may be written only while the block is idle.
// One request is in work at a time. A sample keeps req.ready low after
// acceptance through DIP, UPD, ACC1 and ACC2 (dipole former 2 stages, cell
// product and accumulate pipeline), so a new sample is taken only once the
// last is accumulated; every lag cell updates in parallel. A lag read sends
// a token through the LAGS cell readout stages into the result register.
// Axis results are registered at acceptance; clear acts the cycle after.
// Reset clears history, accumulators, the sample count and the output slot,
// and loads the default charges. A stalled response waits in the output
// register while the next request is accepted; a later read holds in its
// final step until the output register is free.
`default_nettype none

module dipole_lag_autocorrelator_top
	import dlac_pkg::*;
#(
	parameter int LAGS = LAGS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	dlac_req_if.sink   req,
	dlac_rsp_if.source rsp,
	dlac_cfg_if.sink   cfg
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_DIP   = 8'b0000_0010,
		ST_UPD   = 8'b0000_0100,
		ST_ACC1  = 8'b0000_1000,
		ST_ACC2  = 8'b0001_0000,
		ST_RLAG  = 8'b0010_0000,
		ST_RWAIT = 8'b0100_0000,
		ST_RESP  = 8'b1000_0000
	} state_t;

	state_t           state_q, state_d;
	charge_t          co_q, ch_q;
	cnt_t             samples_q;
	logic [SEL_W-1:0] sel_q;
	acc_t             res_value_q;
	cnt_t             res_count_q;
	logic             rsp_v_q;
	acc_t             rsp_value_q;
	cnt_t             rsp_count_q;

	logic             req_acc;
	logic             take;
	logic             rd_launch;
	logic             rsp_load;
	step_ctrl_t       ctl;
	vec_t             dip;
	acc_t             ax_sum [AXES];
	acc_t             ax_sq [AXES];
	acc_t             axis_value;
	cnt_t             axis_count;
	cnt_t             lag_count;
	cnt_t             sel_ext;

	vec_t             part_w [LAGS];
	logic             pv_w [LAGS];
	vec_t             hist_w [LAGS];
	logic             hv_w [LAGS];
	rd_tok_t          rd_w [LAGS+1];

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			co_q <= CO_RESET;
			ch_q <= CH_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_CHARGE_OXYGEN:   co_q <= cfg.data;
				REG_CHARGE_HYDROGEN: ch_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// controller
	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid & req.ready;

	always_comb begin
		state_d   = state_q;
		take      = 1'b0;
		rd_launch = 1'b0;
		rsp_load  = 1'b0;
		ctl       = '{upd: 1'b0, clr: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					unique case (req.command) inside
						CMD_SAMPLE: begin
							take    = 1'b1;
							state_d = ST_DIP;
						end
						CMD_READ_LAG: state_d = ST_RLAG;
						CMD_READ_SUM, CMD_READ_SQ: state_d = ST_RESP;
						CMD_CLEAR: ctl.clr = 1'b1;
						default: ;
					endcase
				end
			end
			ST_DIP: state_d = ST_UPD;
			ST_UPD: begin
				ctl.upd = 1'b1;
				state_d = ST_ACC1;
			end
			ST_ACC1: state_d = ST_ACC2;
			ST_ACC2: state_d = ST_IDLE;
			ST_RLAG: begin
				rd_launch = 1'b1;
				state_d   = ST_RWAIT;
			end
			ST_RWAIT: begin
				if (rd_w[LAGS].v) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (!rsp_v_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_q <= '0;
		end else if (ctl.clr) begin
			samples_q <= '0;
		end else if (ctl.upd && samples_q != '1) begin
			samples_q <= samples_q + cnt_t'(1);
		end
	end

	// read results
	assign sel_ext = CNT_W'(req.select_index);

	always_comb begin
		axis_value = '0;
		axis_count = '0;
		if (sel_ext < CNT_W'(AXES)) begin
			axis_value = (req.command == CMD_READ_SUM) ?
				ax_sum[req.select_index[AX_IDX_W-1:0]] :
				ax_sq[req.select_index[AX_IDX_W-1:0]];
			axis_count = samples_q;
		end
	end

	assign lag_count = (sel_ext < CNT_W'(LAGS) && samples_q > sel_ext) ?
		samples_q - sel_ext : '0;

	always_ff @(posedge clk) begin
		if (req_acc) begin
			sel_q <= req.select_index;
			if (req.command == CMD_READ_LAG) begin
				res_count_q <= lag_count;
			end else begin
				res_value_q <= axis_value;
				res_count_q <= axis_count;
			end
		end else if (state_q == ST_RWAIT && rd_w[LAGS].v) begin
			res_value_q <= rd_w[LAGS].data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_v_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_value_q <= res_value_q;
			rsp_count_q <= res_count_q;
		end
	end

	assign rsp.valid      = rsp_v_q;
	assign rsp.value      = rsp_value_q;
	assign rsp.pair_count = rsp_count_q;

	// datapath
	dlac_dipole u_dipole (
		.clk    (clk),
		.take   (take),
		.co     (co_q),
		.ch     (ch_q),
		.ox     (req.oxygen_x),
		.oy     (req.oxygen_y),
		.oz     (req.oxygen_z),
		.hx     (req.hydrogen_x),
		.hy     (req.hydrogen_y),
		.hz     (req.hydrogen_z),
		.dipole (dip)
	);

	dlac_axis u_axis (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctl),
		.d      (dip),
		.sum    (ax_sum),
		.sq     (ax_sq)
	);

	assign rd_w[0] = '{v: rd_launch, data: '0};

	for (genvar i = 0; i < LAGS; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign part_w[i] = dip;
			assign pv_w[i]   = 1'b1;
		end else begin : g_link
			assign part_w[i] = hist_w[i-1];
			assign pv_w[i]   = hv_w[i-1];
		end

		dlac_cell #(
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctl),
			.sel        (sel_q),
			.d          (dip),
			.part       (part_w[i]),
			.part_valid (pv_w[i]),
			.hist       (hist_w[i]),
			.hist_valid (hv_w[i]),
			.rd_prev    (rd_w[i]),
			.rd_next    (rd_w[i+1])
		);
	end

	// checks
	a_rsp_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == ST_RESP))
		else $error("response raised outside the response step");

	a_token_waited: assert property (@(posedge clk) disable iff (!arst_n)
		rd_w[LAGS].v |-> state_q == ST_RWAIT)
		else $error("readout token left the chain while not awaited");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.clr |=> samples_q >= $past(samples_q))
		else $error("sample count dropped without clear");

endmodule

`default_nettype wire

@@ rtl/core/dlac_dipole.sv @@
// dipole former: charge weighted position sum truncated to q14.16
`default_nettype none

module dlac_dipole
	import dlac_pkg::*;
(
	input  logic    clk,
	input  logic    take,
	input  charge_t co,
	input  charge_t ch,
	input  pos_t    ox,
	input  pos_t    oy,
	input  pos_t    oz,
	input  pos_t    hx,
	input  pos_t    hy,
	input  pos_t    hz,
	output vec_t    dipole
);

	logic signed [CP_W-1:0] pox_s1, poy_s1, poz_s1;
	logic signed [CP_W-1:0] phx_s1, phy_s1, phz_s1;
	logic signed [CS_W-1:0] sx, sy, sz;
	vec_t d_s2;

	always_ff @(posedge clk) begin
		if (take) begin
			pox_s1 <= co * ox;
			poy_s1 <= co * oy;
			poz_s1 <= co * oz;
			phx_s1 <= ch * hx;
			phy_s1 <= ch * hy;
			phz_s1 <= ch * hz;
		end
	end

	assign sx = CS_W'(pox_s1) + CS_W'(phx_s1);
	assign sy = CS_W'(poy_s1) + CS_W'(phy_s1);
	assign sz = CS_W'(poz_s1) + CS_W'(phz_s1);

	// arithmetic shift right is the floor division
	always_ff @(posedge clk) begin
		d_s2.x <= sx[CS_W-1:DIP_SHIFT];
		d_s2.y <= sy[CS_W-1:DIP_SHIFT];
		d_s2.z <= sz[CS_W-1:DIP_SHIFT];
	end

	assign dipole = d_s2;

endmodule

`default_nettype wire

@@ rtl/core/dlac_cell.sv @@
// one lag cell: history tap, lag accumulator and readout stage
`default_nettype none

module dlac_cell
	import dlac_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  step_ctrl_t       ctrl,
	input  logic [SEL_W-1:0] sel,
	input  vec_t             d,
	input  vec_t             part,
	input  logic             part_valid,
	output vec_t             hist,
	output logic             hist_valid,
	input  rd_tok_t          rd_prev,
	output rd_tok_t          rd_next
);

	vec_t                    hist_q;
	logic                    hist_v_q;
	logic signed [PROD_W-1:0] px_s1, py_s1, pz_s1;
	logic                    v_s1;
	logic signed [DOT_W-1:0] dot_s2;
	logic                    v_s2;
	acc_t                    acc_q;
	logic                    rd_v_q;
	acc_t                    rd_data_q;
	logic                    hit;

	always_ff @(posedge clk) begin
		if (ctrl.upd) begin
			hist_q <= part;
			px_s1  <= d.x * part.x;
			py_s1  <= d.y * part.y;
			pz_s1  <= d.z * part.z;
		end
		dot_s2 <= DOT_W'(px_s1) + DOT_W'(py_s1) + DOT_W'(pz_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_v_q <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			acc_q    <= '0;
		end else if (ctrl.clr) begin
			hist_v_q <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			acc_q    <= '0;
		end else begin
			if (ctrl.upd) begin
				hist_v_q <= part_valid;
			end
			v_s1 <= ctrl.upd & part_valid;
			v_s2 <= v_s1;
			if (v_s2) begin
				acc_q <= sat_add(acc_q, ACC_W'(dot_s2));
			end
		end
	end

	// readout token picks up this accumulator when the lag matches
	assign hit = (32'(sel) == 32'(IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_q <= 1'b0;
		end else begin
			rd_v_q <= rd_prev.v;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= (rd_prev.v && hit) ? acc_q : rd_prev.data;
	end

	assign hist       = hist_q;
	assign hist_valid = hist_v_q;
	assign rd_next    = '{v: rd_v_q, data: rd_data_q};

endmodule

`default_nettype wire

@@ rtl/core/dlac_axis.sv @@
// per axis saturating sums and squared sums of the dipole
`default_nettype none

module dlac_axis
	import dlac_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  step_ctrl_t ctrl,
	input  vec_t       d,
	output acc_t       sum [AXES],
	output acc_t       sq [AXES]
);

	dip_t                     dv [AXES];
	dip_t                     lin_s1 [AXES];
	logic signed [PROD_W-1:0] sq_s1 [AXES];
	logic                     v_s1;
	acc_t                     sum_q [AXES];
	acc_t                     sq_q [AXES];

	assign dv[0] = d.x;
	assign dv[1] = d.y;
	assign dv[2] = d.z;

	always_ff @(posedge clk) begin
		for (int k = 0; k < AXES; k++) begin
			if (ctrl.upd) begin
				lin_s1[k] <= dv[k];
				sq_s1[k]  <= dv[k] * dv[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int k = 0; k < AXES; k++) begin
				sum_q[k] <= '0;
				sq_q[k]  <= '0;
			end
		end else if (ctrl.clr) begin
			v_s1 <= 1'b0;
			for (int k = 0; k < AXES; k++) begin
				sum_q[k] <= '0;
				sq_q[k]  <= '0;
			end
		end else begin
			v_s1 <= ctrl.upd;
			if (v_s1) begin
				for (int k = 0; k < AXES; k++) begin
					sum_q[k] <= sat_add(sum_q[k], acc_t'(lin_s1[k]) <<< FRAC_SHIFT);
					sq_q[k]  <= sat_add(sq_q[k], acc_t'(sq_s1[k]));
				end
			end
		end
	end

	assign sum = sum_q;
	assign sq  = sq_q;

endmodule

`default_nettype wire
